FILE: src/tiq_pkg.sv
package tiq_pkg;

  // Fixed field widths of the request and result words
  localparam int IN_W     = 16;
  localparam int OUT_W    = 48;
  localparam int STATUS_W = 2;

  // Widths inside the x^4 pipeline
  localparam int XQ_W = 24;  // |x| in Q.16
  localparam int SQ_W = 31;  // x^2 in Q.16
  localparam int Q4_W = 41;  // x^4 in Q.12

  localparam logic [OUT_W-1:0] POS_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] NEG_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_ZERO = 2'd1,
    STAT_SAT  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV,
    OP_ISSUE_A,
    OP_ISSUE_B,
    OP_ISSUE_X,
    OP_DRAIN,
    OP_MUL,
    OP_FINISH
  } dp_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_ISSUE_A,
    ST_ISSUE_B,
    ST_ISSUE_X,
    ST_DRAIN,
    ST_MUL,
    ST_FINISH
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic zero_count;
    logic cnt_zero;
    logic cnt_one;
    logic pipe_empty;
  } dp_status_t;

endpackage

FILE: src/tiq_if.sv
interface tiq_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [tiq_pkg::IN_W-1:0]    left_end;
  logic signed [tiq_pkg::IN_W-1:0]    right_end;
  logic        [tiq_pkg::IN_W-1:0]    trapezoids;

  modport source (output valid, left_end, right_end, trapezoids, input ready);
  modport sink   (input valid, left_end, right_end, trapezoids, output ready);
endinterface

interface tiq_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [tiq_pkg::OUT_W-1:0]   integral;
  logic        [tiq_pkg::STATUS_W-1:0] status;

  modport source (output valid, integral, status, input ready);
  modport sink   (input valid, integral, status, output ready);
endinterface

FILE: src/tiq_datapath.sv
module tiq_datapath #(
  parameter int COUNT_BITS         = 16,
  parameter int STEP_FRACTION_BITS = 24
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  tiq_pkg::dp_cmd_t                   cmd,
  output tiq_pkg::dp_status_t                st,
  input  logic signed [tiq_pkg::IN_W-1:0]    left_end,
  input  logic signed [tiq_pkg::IN_W-1:0]    right_end,
  input  logic        [tiq_pkg::IN_W-1:0]    trapezoids,
  output logic signed [tiq_pkg::OUT_W-1:0]   integral,
  output logic        [tiq_pkg::STATUS_W-1:0] status
);

  localparam int IW   = tiq_pkg::IN_W;
  localparam int OW   = tiq_pkg::OUT_W;
  localparam int NW   = (COUNT_BITS < IW) ? COUNT_BITS : IW;
  localparam int F    = STEP_FRACTION_BITS;
  localparam int HW   = F + 8;          // |h| and quotient
  localparam int XW   = F + 9;          // signed sample point
  localparam int TW   = NW + 43;        // weighted sum of x^4
  localparam int PW   = TW + HW;        // full product
  localparam int RW   = PW - F;         // rounded product
  localparam int LHW  = $clog2(HW);
  localparam int CNTW = (NW > LHW) ? NW : LHW;
  localparam int XQW  = tiq_pkg::XQ_W;
  localparam int SQW  = tiq_pkg::SQ_W;
  localparam int Q4W  = tiq_pkg::Q4_W;

  logic signed [IW-1:0] a_r, b_r;
  logic [NW-1:0]        n_r;
  logic                 zero_r, neg_r;
  logic [HW-1:0]        dq_r;
  logic [NW-1:0]        rem_r;
  logic [CNTW-1:0]      cnt_r;
  logic signed [XW-1:0] x_r;
  logic [TW-1:0]        acc_r;
  logic [PW-1:0]        prod_r;
  logic [OW-1:0]        integral_r;
  logic [tiq_pkg::STATUS_W-1:0] status_r;

  // x^4 pipeline
  logic                 v1_r, v2_r, v3_r;
  logic                 dbl1_r, dbl2_r, dbl3_r;
  logic [XQW-1:0]       xq_r;
  logic [SQW-1:0]       sq_r;
  logic [Q4W-1:0]       q4_r;

  // request decode
  logic signed [IW:0]   diff;
  logic [IW:0]          diff_mag;
  logic [HW-1:0]        dividend;

  assign diff     = {right_end[IW-1], right_end} - {left_end[IW-1], left_end};
  assign diff_mag = diff[IW] ? ((IW+1)'(0) - diff) : diff;
  assign dividend = HW'(diff_mag[IW-1:0]) << (F - 8);

  // one restoring divide step
  logic [NW:0] rem_sh;
  logic [NW:0] rem_sub;
  logic        q_bit;

  assign rem_sh  = {rem_r, dq_r[HW-1]};
  assign rem_sub = rem_sh - {1'b0, n_r};
  assign q_bit   = (rem_sh >= {1'b0, n_r});

  // sample points
  logic signed [XW-1:0] h_s, a_f, b_f, samp;
  logic [XW-1:0]        samp_neg;
  logic [HW-1:0]        mag;
  logic                 issue, dbl;

  assign h_s = neg_r ? (XW'(0) - {1'b0, dq_r}) : {1'b0, dq_r};
  assign a_f = {{(XW-IW){a_r[IW-1]}}, a_r} <<< (F - 8);
  assign b_f = {{(XW-IW){b_r[IW-1]}}, b_r} <<< (F - 8);

  always_comb begin
    samp  = x_r;
    issue = 1'b0;
    dbl   = 1'b0;
    case (cmd.op)
      tiq_pkg::OP_ISSUE_A: begin
        samp  = a_f;
        issue = 1'b1;
      end
      tiq_pkg::OP_ISSUE_B: begin
        samp  = b_f;
        issue = 1'b1;
      end
      tiq_pkg::OP_ISSUE_X: begin
        samp  = x_r;
        issue = 1'b1;
        dbl   = 1'b1;
      end
      default: begin
        samp  = x_r;
        issue = 1'b0;
      end
    endcase
  end

  assign samp_neg = XW'(0) - samp;
  assign mag      = samp[XW-1] ? samp_neg[HW-1:0] : samp[HW-1:0];

  // scale |x| to 16 fraction bits, rounding when F exceeds 16
  logic [XQW-1:0] xq_c;
  generate
    if (F > 16) begin : g_round_down
      logic [HW:0] xq_sum;
      logic [HW:0] xq_shr;
      assign xq_sum = {1'b0, mag} + ((HW+1)'(1) << (F - 17));
      assign xq_shr = xq_sum >> (F - 16);
      assign xq_c   = xq_shr[XQW-1:0];
    end else begin : g_scale_up
      assign xq_c = XQW'(mag) << (16 - F);
    end
  endgenerate

  logic [2*XQW-1:0] xsq;
  logic [2*XQW-1:0] xsq_rnd;
  logic [2*SQW-1:0] sq4;
  logic [2*SQW-1:0] sq4_rnd;

  assign xsq     = xq_r * xq_r;
  assign xsq_rnd = (xsq + ((2*XQW)'(1) << 15)) >> 16;
  assign sq4     = sq_r * sq_r;
  assign sq4_rnd = (sq4 + ((2*SQW)'(1) << 19)) >> 20;

  // rounding and clamp of the final product
  logic [PW:0]   rsum;
  logic [RW-1:0] rmag;
  logic [OW-1:0] res_val;
  logic [tiq_pkg::STATUS_W-1:0] res_stat;

  assign rsum = {1'b0, prod_r} + ((PW+1)'(1) << F);
  assign rmag = rsum[PW:F+1];

  always_comb begin
    if (zero_r) begin
      res_val  = '0;
      res_stat = tiq_pkg::STAT_ZERO;
    end else if (neg_r) begin
      if (rmag > RW'(tiq_pkg::NEG_MIN)) begin
        res_val  = tiq_pkg::NEG_MIN;
        res_stat = tiq_pkg::STAT_SAT;
      end else begin
        res_val  = OW'(0) - rmag[OW-1:0];
        res_stat = tiq_pkg::STAT_OK;
      end
    end else begin
      if (rmag > RW'(tiq_pkg::POS_MAX)) begin
        res_val  = tiq_pkg::POS_MAX;
        res_stat = tiq_pkg::STAT_SAT;
      end else begin
        res_val  = rmag[OW-1:0];
        res_stat = tiq_pkg::STAT_OK;
      end
    end
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    dbl1_r <= dbl;
    dbl2_r <= dbl1_r;
    dbl3_r <= dbl2_r;
    xq_r   <= xq_c;
    sq_r   <= xsq_rnd[SQW-1:0];
    q4_r   <= sq4_rnd[Q4W-1:0];
  end

  // accumulate x^4; interior points count twice
  always_ff @(posedge clk) begin
    if (cmd.op == tiq_pkg::OP_LOAD) begin
      acc_r <= '0;
    end else if (v3_r) begin
      acc_r <= acc_r + (dbl3_r ? (TW'(q4_r) << 1) : TW'(q4_r));
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      tiq_pkg::OP_LOAD: begin
        a_r    <= left_end;
        b_r    <= right_end;
        n_r    <= trapezoids[NW-1:0];
        zero_r <= (trapezoids[NW-1:0] == '0);
        neg_r  <= diff[IW];
        dq_r   <= dividend;
        rem_r  <= '0;
        cnt_r  <= CNTW'(HW - 1);
      end
      tiq_pkg::OP_DIV: begin
        rem_r <= q_bit ? rem_sub[NW-1:0] : rem_sh[NW-1:0];
        dq_r  <= {dq_r[HW-2:0], q_bit};
        cnt_r <= cnt_r - 1'b1;
      end
      tiq_pkg::OP_ISSUE_A: begin
        x_r   <= a_f + h_s;
        cnt_r <= CNTW'(n_r) - 1'b1;
      end
      tiq_pkg::OP_ISSUE_X: begin
        x_r   <= x_r + h_s;
        cnt_r <= cnt_r - 1'b1;
      end
      tiq_pkg::OP_DRAIN: begin
        prod_r <= '0;
        cnt_r  <= CNTW'(HW - 1);
      end
      tiq_pkg::OP_MUL: begin
        prod_r <= (prod_r << 1) + (dq_r[HW-1] ? PW'(acc_r) : PW'(0));
        dq_r   <= dq_r << 1;
        cnt_r  <= cnt_r - 1'b1;
      end
      tiq_pkg::OP_FINISH: begin
        integral_r <= res_val;
        status_r   <= res_stat;
      end
      default: begin
      end
    endcase
  end

  assign st.zero_count = zero_r;
  assign st.cnt_zero   = (cnt_r == '0);
  assign st.cnt_one    = (cnt_r == CNTW'(1));
  assign st.pipe_empty = !(v1_r || v2_r || v3_r);

  assign integral = integral_r;
  assign status   = status_r;

endmodule

FILE: src/tiq_ctrl.sv
module tiq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output tiq_pkg::dp_cmd_t    cmd,
  input  tiq_pkg::dp_status_t st
);

  tiq_pkg::ctrl_state_t state_r, state_nxt;
  logic                 out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tiq_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd.op        = tiq_pkg::OP_NONE;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      tiq_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = tiq_pkg::OP_LOAD;
          state_nxt = tiq_pkg::ST_DIV;
        end
      end
      tiq_pkg::ST_DIV: begin
        if (st.zero_count) begin
          state_nxt = tiq_pkg::ST_FINISH;
        end else begin
          cmd.op = tiq_pkg::OP_DIV;
          if (st.cnt_zero) state_nxt = tiq_pkg::ST_ISSUE_A;
        end
      end
      tiq_pkg::ST_ISSUE_A: begin
        cmd.op    = tiq_pkg::OP_ISSUE_A;
        state_nxt = tiq_pkg::ST_ISSUE_B;
      end
      tiq_pkg::ST_ISSUE_B: begin
        cmd.op    = tiq_pkg::OP_ISSUE_B;
        state_nxt = st.cnt_zero ? tiq_pkg::ST_DRAIN : tiq_pkg::ST_ISSUE_X;
      end
      tiq_pkg::ST_ISSUE_X: begin
        cmd.op = tiq_pkg::OP_ISSUE_X;
        if (st.cnt_one) state_nxt = tiq_pkg::ST_DRAIN;
      end
      tiq_pkg::ST_DRAIN: begin
        cmd.op = tiq_pkg::OP_DRAIN;
        if (st.pipe_empty) state_nxt = tiq_pkg::ST_MUL;
      end
      tiq_pkg::ST_MUL: begin
        cmd.op = tiq_pkg::OP_MUL;
        if (st.cnt_zero) state_nxt = tiq_pkg::ST_FINISH;
      end
      tiq_pkg::ST_FINISH: begin
        if (!out_valid_r) begin
          cmd.op        = tiq_pkg::OP_FINISH;
          out_valid_nxt = 1'b1;
          state_nxt     = tiq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tiq_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_ready  = (state_r == tiq_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

`ifndef SYNTH
  a_accept_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == tiq_pkg::ST_DIV))
    else $error("accepted word did not start the divide");

  a_mul_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tiq_pkg::ST_MUL) |-> st.pipe_empty)
    else $error("product started with samples still in flight");

  a_issue_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tiq_pkg::ST_ISSUE_X) |-> !st.cnt_zero)
    else $error("interior point counter wrapped");

  a_finish_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tiq_pkg::ST_FINISH && !out_valid_r) |=>
      (out_valid_r && state_r == tiq_pkg::ST_IDLE))
    else $error("finished result not presented");
`endif

endmodule

FILE: src/trapezoid_integrate_quartic.sv
// A zero trapezoid count skips the divide, the sample points and the product and
// goes straight to the result with status STAT_ZERO.
// Throughput: one word at a time; the x^4 pipeline takes one sample point a cycle, so
// the interior loop sets the rate, plus a bit-serial divide and multiply over the
// STEP_FRACTION_BITS+8 bits of h. The next word is taken while a result waits.
// Reset: synchronous, active low; clears the sequencer and the valid flags.
module trapezoid_integrate_quartic #(
  parameter int COUNT_BITS         = 16,
  parameter int STEP_FRACTION_BITS = 24
) (
  input  logic      clk,
  input  logic      rst_n,
  tiq_in_if.sink    in_ch,
  tiq_out_if.source out_ch
);

  tiq_pkg::dp_cmd_t    cmd;
  tiq_pkg::dp_status_t st;

  // Sequencer: load the word, divide out h one quotient bit a cycle, issue
  // both endpoints and then every interior point into the x^4 pipeline,
  // drain the pipeline, multiply the weighted sum by |h| one bit a cycle,
  // then round, clamp and hand the word to the output register.
  tiq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .st        (st)
  );

  // Datapath: operand registers, restoring divider, sample-point stepper,
  // three-stage x^4 pipeline, accumulator, serial multiplier and the
  // output payload register.
  tiq_datapath #(
    .COUNT_BITS         (COUNT_BITS),
    .STEP_FRACTION_BITS (STEP_FRACTION_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .left_end   (in_ch.left_end),
    .right_end  (in_ch.right_end),
    .trapezoids (in_ch.trapezoids),
    .integral   (out_ch.integral),
    .status     (out_ch.status)
  );

endmodule
